[rtl/keyframe_track_interpolator_defines.svh]
// assertion macros shared by the checker of the keyframe track interpolator
`ifndef KEYFRAME_TRACK_INTERPOLATOR_DEFINES_SVH
`define KEYFRAME_TRACK_INTERPOLATOR_DEFINES_SVH

// same-cycle implication, checked on clk while out of reset
`define KTI_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keyframe track interpolator check failed");

// next-cycle implication, checked on clk while out of reset
`define KTI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keyframe track interpolator check failed");

`endif

[rtl/kti_pkg.sv]
// shared types and constants of the keyframe track interpolator
package kti_pkg;

  localparam int DEF_MAX_KEYS  = 64;
  localparam int DEF_FRAC_BITS = 16;

  // command codes
  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_EVAL  = 2'd2;

  // interpolation modes
  localparam logic [1:0] MODE_STEP   = 2'd0;
  localparam logic [1:0] MODE_LINEAR = 2'd1;
  localparam logic [1:0] MODE_SMOOTH = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // register indexes
  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  // one queued command
  typedef struct packed {
    logic [1:0]         cmd;
    logic               is_add;
    logic               is_clear;
    logic               is_eval;
    logic signed [31:0] stime;
    logic [127:0]       vals;
  } kti_item_t;

  // one result
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
    logic [5:0]         prev_index;
    logic [5:0]         next_index;
    logic               found;
    logic [1:0]         status;
    logic [6:0]         key_count;
    logic signed [31:0] duration;
  } kti_result_t;

  // configuration seen by the back end
  typedef struct packed {
    logic [1:0] mode;
    logic       four_comp;
  } kti_cfg_t;

endpackage

[rtl/kti_ram.sv]
// generic single-write single-read ram with registered read data
module kti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/kti_front.sv]
// command front end: accepts and classifies commands into a two-entry queue
module kti_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_command,
  input  logic signed [31:0] in_sample_time,
  input  logic signed [31:0] in_value_x,
  input  logic signed [31:0] in_value_y,
  input  logic signed [31:0] in_value_z,
  input  logic signed [31:0] in_value_w,
  input  logic               pop,
  output logic               q_valid,
  output kti_pkg::kti_item_t q_item
);
  import kti_pkg::*;

  kti_item_t  ent_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       do_pop;
  kti_item_t  cls;

  // classify the incoming command
  always_comb begin
    cls.cmd      = in_command;
    cls.is_add   = (in_command == CMD_ADD);
    cls.is_clear = (in_command == CMD_CLEAR);
    cls.is_eval  = (in_command == CMD_EVAL);
    cls.stime    = in_sample_time;
    cls.vals     = {in_value_w, in_value_z, in_value_y, in_value_x};
  end

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign do_pop  = pop && q_valid;
  assign q_item  = ent_r[rptr_r];

  // queue pointers
  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = do_pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= cls;
    end
  end

endmodule

[rtl/kti_back.sv]
// command back end: key table sequencer, bracket scan, divider and blend
module kti_back #(
  parameter int MAX_KEYS  = kti_pkg::DEF_MAX_KEYS,
  parameter int FRAC_BITS = kti_pkg::DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  kti_pkg::kti_cfg_t    cfg,
  input  logic                 q_valid,
  input  kti_pkg::kti_item_t   q_item,
  output logic                 pop,
  output logic                 res_valid,
  output kti_pkg::kti_result_t res
);
  import kti_pkg::*;

  localparam int IW  = $clog2(MAX_KEYS);
  localparam int CW  = $clog2(MAX_KEYS + 1);
  localparam int F   = FRAC_BITS;
  localparam int DCW = $clog2(F + 2);
  localparam int PW  = 33 + F + 2;
  localparam int SQW = 2 * F + 2;
  localparam int MW  = 2 * F + 3;
  localparam logic [CW-1:0]  MAXK   = CW'(MAX_KEYS);
  localparam logic [DCW-1:0] DLAST  = DCW'(F);
  localparam logic [F+1:0]   THREE  = (F + 2)'(3) << F;

  // sequencer states
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_INS_RD = 5'd1;
  localparam logic [4:0] S_INS_CK = 5'd2;
  localparam logic [4:0] S_INS_WR = 5'd3;
  localparam logic [4:0] S_E_RD0  = 5'd4;
  localparam logic [4:0] S_E_CK0  = 5'd5;
  localparam logic [4:0] S_E_CKL  = 5'd6;
  localparam logic [4:0] S_E_SRD  = 5'd7;
  localparam logic [4:0] S_E_SCK  = 5'd8;
  localparam logic [4:0] S_DIV    = 5'd9;
  localparam logic [4:0] S_SEL    = 5'd10;
  localparam logic [4:0] S_SQ1    = 5'd11;
  localparam logic [4:0] S_SQ2    = 5'd12;
  localparam logic [4:0] S_FA     = 5'd13;
  localparam logic [4:0] S_FB     = 5'd14;
  localparam logic [4:0] S_FC     = 5'd15;
  localparam logic [4:0] S_MUL    = 5'd16;
  localparam logic [4:0] S_ACC    = 5'd17;
  localparam logic [4:0] S_DONE   = 5'd18;

  logic [4:0]          state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic signed [31:0]  last_r, last_nxt;
  logic [1:0]          cmd_r;
  logic signed [31:0]  q_r;
  logic [127:0]        nv_r;
  logic [IW-1:0]       i_r, i_nxt;
  logic [IW-1:0]       prev_r, prev_nxt;
  logic [IW-1:0]       next_r, next_nxt;
  logic signed [31:0]  tprev_r, tprev_nxt;
  logic [34:0]         rem_r, rem_nxt;
  logic [32:0]         range_r, range_nxt;
  logic [F:0]          quo_r, quo_nxt;
  logic [DCW-1:0]      dcnt_r, dcnt_nxt;
  logic [F:0]          t2_r;
  logic [F:0]          s_r, s_nxt;
  logic [127:0]        a_r, b_r;
  logic [1:0]          comp_r, comp_nxt;
  logic signed [PW-1:0] prod_r;
  logic [127:0]        acc_r, acc_nxt;
  logic                found_r, found_nxt;
  logic [1:0]          status_r, status_nxt;
  logic                load_a, load_b, do_mul, do_sq1, take;

  // memory ports
  logic                we;
  logic [IW-1:0]       waddr, raddr;
  logic [31:0]         t_wdata, t_rdata;
  logic [127:0]        v_wdata, v_rdata;
  logic signed [31:0]  t_rd;

  kti_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_times (
    .clk(clk), .we(we), .waddr(waddr), .wdata(t_wdata), .raddr(raddr), .rdata(t_rdata)
  );

  kti_ram #(.WIDTH(128), .DEPTH(MAX_KEYS)) u_values (
    .clk(clk), .we(we), .waddr(waddr), .wdata(v_wdata), .raddr(raddr), .rdata(v_rdata)
  );

  assign t_rd = $signed(t_rdata);

  // helpers for the datapath
  logic [IW-1:0]        i_up;
  logic [IW-1:0]        last_idx;
  logic                 ins_top;
  logic                 ge;
  logic [34:0]          rem_sub;
  logic [SQW-1:0]       sq_full;
  logic [F+1:0]         m_fac;
  logic [MW-1:0]        sm_full;
  logic signed [32:0]   diff;
  logic signed [PW-1:0] sh;
  logic signed [PW-1:0] sum;
  logic signed [31:0]   a_c;
  logic signed [31:0]   sat;

  assign i_up     = i_r + IW'(1);
  assign last_idx = IW'(count_r - CW'(1));
  assign ins_top  = ((CW'(i_r) + CW'(1)) == count_r);
  assign ge       = (rem_r >= {2'b00, range_r});
  assign rem_sub  = ge ? (rem_r - {2'b00, range_r}) : rem_r;
  assign sq_full  = SQW'(quo_r) * SQW'(quo_r);
  assign m_fac    = THREE - {quo_r, 1'b0};
  assign sm_full  = MW'(t2_r) * MW'(m_fac);
  assign diff     = 33'(signed'(b_r[32*comp_r +: 32])) - 33'(signed'(a_r[32*comp_r +: 32]));
  assign a_c      = signed'(a_r[32*comp_r +: 32]);
  assign sh       = prod_r >>> F;
  assign sum      = PW'(a_c) + sh;

  // saturate the blended component to 32 bits
  always_comb begin
    if (sum > $signed({{(PW-32){1'b0}}, 32'h7fffffff})) begin
      sat = 32'sh7fffffff;
    end else if (sum < $signed({{(PW-32){1'b1}}, 32'h80000000})) begin
      sat = 32'sh80000000;
    end else begin
      sat = sum[31:0];
    end
  end

  // read address by state
  always_comb begin
    unique case (state_r)
      S_E_CK0:  raddr = last_idx;
      S_E_SRD:  raddr = i_r;
      S_INS_RD: raddr = i_r;
      S_FA:     raddr = prev_r;
      S_FB:     raddr = next_r;
      default:  raddr = '0;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    last_nxt   = last_r;
    i_nxt      = i_r;
    prev_nxt   = prev_r;
    next_nxt   = next_r;
    tprev_nxt  = tprev_r;
    rem_nxt    = rem_r;
    range_nxt  = range_r;
    quo_nxt    = quo_r;
    dcnt_nxt   = dcnt_r;
    s_nxt      = s_r;
    comp_nxt   = comp_r;
    acc_nxt    = acc_r;
    found_nxt  = found_r;
    status_nxt = status_r;
    pop        = 1'b0;
    take       = 1'b0;
    load_a     = 1'b0;
    load_b     = 1'b0;
    do_mul     = 1'b0;
    do_sq1     = 1'b0;
    we         = 1'b0;
    waddr      = '0;
    t_wdata    = q_r;
    v_wdata    = nv_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          pop        = 1'b1;
          take       = 1'b1;
          acc_nxt    = '0;
          prev_nxt   = '0;
          next_nxt   = '0;
          found_nxt  = 1'b0;
          status_nxt = ST_OK;
          if (q_item.is_add) begin
            if (count_r >= MAXK) begin
              status_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else if (count_r == '0) begin
              state_nxt = S_INS_WR;
            end else begin
              i_nxt     = last_idx;
              state_nxt = S_INS_RD;
            end
          end else if (q_item.is_clear) begin
            count_nxt = '0;
            state_nxt = S_DONE;
          end else if (q_item.is_eval) begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
              acc_nxt[127:96] = cfg.four_comp ? (32'd1 << F) : 32'd0;
              state_nxt  = S_DONE;
            end else begin
              found_nxt = 1'b1;
              state_nxt = S_E_RD0;
            end
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_INS_RD: begin
        state_nxt = S_INS_CK;
      end
      S_INS_CK: begin
        we    = 1'b1;
        waddr = i_up;
        if (t_rd > q_r) begin
          // move this key up one slot
          t_wdata = t_rdata;
          v_wdata = v_rdata;
          if (i_r == '0) begin
            state_nxt = S_INS_WR;
          end else begin
            i_nxt     = i_r - IW'(1);
            state_nxt = S_INS_RD;
          end
        end else begin
          if (ins_top) begin
            last_nxt = q_r;
          end
          count_nxt = count_r + CW'(1);
          state_nxt = S_DONE;
        end
      end
      S_INS_WR: begin
        we    = 1'b1;
        waddr = '0;
        if (count_r == '0) begin
          last_nxt = q_r;
        end
        count_nxt = count_r + CW'(1);
        state_nxt = S_DONE;
      end
      S_E_RD0: begin
        state_nxt = S_E_CK0;
      end
      S_E_CK0: begin
        if (q_r <= t_rd) begin
          prev_nxt  = '0;
          next_nxt  = '0;
          s_nxt     = '0;
          state_nxt = S_FA;
        end else begin
          tprev_nxt = t_rd;
          state_nxt = S_E_CKL;
        end
      end
      S_E_CKL: begin
        if (q_r >= t_rd) begin
          prev_nxt  = last_idx;
          next_nxt  = last_idx;
          s_nxt     = '0;
          state_nxt = S_FA;
        end else begin
          i_nxt     = IW'(1);
          state_nxt = S_E_SRD;
        end
      end
      S_E_SRD: begin
        state_nxt = S_E_SCK;
      end
      S_E_SCK: begin
        if (t_rd >= q_r) begin
          next_nxt  = i_r;
          prev_nxt  = i_r - IW'(1);
          rem_nxt   = 35'(33'(q_r) - 33'(tprev_r));
          range_nxt = 33'(t_rd) - 33'(tprev_r);
          quo_nxt   = '0;
          dcnt_nxt  = '0;
          state_nxt = S_DIV;
        end else begin
          tprev_nxt = t_rd;
          i_nxt     = i_up;
          state_nxt = S_E_SRD;
        end
      end
      S_DIV: begin
        // one quotient bit per cycle
        quo_nxt  = {quo_r[F-1:0], ge};
        rem_nxt  = {rem_sub[33:0], 1'b0};
        dcnt_nxt = dcnt_r + DCW'(1);
        if (dcnt_r == DLAST) begin
          state_nxt = S_SEL;
        end
      end
      S_SEL: begin
        if (cfg.mode == MODE_STEP) begin
          s_nxt     = '0;
          state_nxt = S_FA;
        end else if (cfg.mode == MODE_SMOOTH) begin
          state_nxt = S_SQ1;
        end else begin
          s_nxt     = quo_r;
          state_nxt = S_FA;
        end
      end
      S_SQ1: begin
        do_sq1    = 1'b1;
        state_nxt = S_SQ2;
      end
      S_SQ2: begin
        s_nxt     = sm_full[2*F:F];
        state_nxt = S_FA;
      end
      S_FA: begin
        state_nxt = S_FB;
      end
      S_FB: begin
        load_a    = 1'b1;
        state_nxt = S_FC;
      end
      S_FC: begin
        load_b    = 1'b1;
        comp_nxt  = 2'd0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        do_mul    = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        acc_nxt[32*comp_r +: 32] = sat;
        if (comp_r == 2'd3) begin
          state_nxt = S_DONE;
        end else begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = S_MUL;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      res_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      res_valid <= (state_r == S_DONE);
    end
  end

  // datapath registers
  logic [IW+5:0] prev_ext, next_ext;
  logic [CW+6:0] count_ext;
  assign prev_ext  = {6'd0, prev_r};
  assign next_ext  = {6'd0, next_r};
  assign count_ext = {7'd0, count_r};

  always_ff @(posedge clk) begin
    last_r   <= last_nxt;
    i_r      <= i_nxt;
    prev_r   <= prev_nxt;
    next_r   <= next_nxt;
    tprev_r  <= tprev_nxt;
    rem_r    <= rem_nxt;
    range_r  <= range_nxt;
    quo_r    <= quo_nxt;
    dcnt_r   <= dcnt_nxt;
    s_r      <= s_nxt;
    comp_r   <= comp_nxt;
    acc_r    <= acc_nxt;
    found_r  <= found_nxt;
    status_r <= status_nxt;
    if (take) begin
      cmd_r <= q_item.cmd;
      q_r   <= q_item.stime;
      nv_r  <= q_item.vals;
    end
    if (do_sq1) begin
      t2_r <= sq_full[2*F:F];
    end
    if (load_a) begin
      a_r <= v_rdata;
    end
    if (load_b) begin
      b_r <= v_rdata;
    end
    if (do_mul) begin
      prod_r <= PW'(diff) * PW'($signed({1'b0, s_r}));
    end
    if (state_r == S_DONE) begin
      res.x          <= acc_r[31:0];
      res.y          <= acc_r[63:32];
      res.z          <= acc_r[95:64];
      res.w          <= acc_r[127:96];
      res.prev_index <= prev_ext[5:0];
      res.next_index <= next_ext[5:0];
      res.found      <= found_r && (cmd_r == CMD_EVAL);
      res.status     <= status_r;
      res.key_count  <= count_ext[6:0];
      res.duration   <= (count_r != '0) ? last_r : 32'sd0;
    end
  end

endmodule

[rtl/keyframe_track_interpolator.sv]
// top level of the keyframe track interpolator
// Commands (add key, clear, evaluate) go into a two-entry queue while busy is
// low; each one gives a single result, shown for one cycle with out_valid, and
// results cannot be held off. An add shuffles the keys above the insert point
// up one slot, read then write, through the key memories. An evaluate runs a
// serial scan of the key time memory and the one-bit-per-cycle divider (and
// the squaring states in smoothstep mode); a query clamped to the first or
// last key skips both, and an empty-table query, like a clear, goes straight
// to the result. Commands pass through the registered queue on their way in.
module keyframe_track_interpolator #(
  parameter int MAX_KEYS  = kti_pkg::DEF_MAX_KEYS,
  parameter int FRAC_BITS = kti_pkg::DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_command,
  input  logic signed [31:0] in_sample_time,
  input  logic signed [31:0] in_value_x,
  input  logic signed [31:0] in_value_y,
  input  logic signed [31:0] in_value_z,
  input  logic signed [31:0] in_value_w,
  output logic               out_valid,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic signed [31:0] out_w,
  output logic [5:0]         out_prev_index,
  output logic [5:0]         out_next_index,
  output logic               out_found,
  output logic [1:0]         out_status,
  output logic [6:0]         out_key_count,
  output logic signed [31:0] out_duration,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import kti_pkg::*;

  logic [1:0]  mode_r;
  logic [2:0]  ccount_r;
  logic        wr_en;
  kti_cfg_t    cfg;
  logic        pop;
  logic        q_valid;
  kti_item_t   q_item;
  kti_result_t res;

  // configuration registers
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_LINEAR;
      ccount_r <= 3'd1;
    end else if (wr_en) begin
      if (paddr[2] == REG_MODE) begin
        mode_r <= pwdata[1:0];
      end else begin
        ccount_r <= pwdata[2:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_COUNT) ? {29'd0, ccount_r} : {30'd0, mode_r};

  assign cfg.mode      = mode_r;
  assign cfg.four_comp = (ccount_r == 3'd4);

  kti_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_sample_time(in_sample_time),
    .in_value_x(in_value_x), .in_value_y(in_value_y),
    .in_value_z(in_value_z), .in_value_w(in_value_w),
    .pop(pop), .q_valid(q_valid), .q_item(q_item)
  );

  kti_back #(.MAX_KEYS(MAX_KEYS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .q_valid(q_valid), .q_item(q_item),
    .pop(pop), .res_valid(out_valid), .res(res)
  );

  // result transfer
  assign out_x          = res.x;
  assign out_y          = res.y;
  assign out_z          = res.z;
  assign out_w          = res.w;
  assign out_prev_index = res.prev_index;
  assign out_next_index = res.next_index;
  assign out_found      = res.found;
  assign out_status     = res.status;
  assign out_key_count  = res.key_count;
  assign out_duration   = res.duration;

endmodule

[rtl/kti_checker.sv]
// port-level checks of the keyframe track interpolator, bound to the top level
`include "keyframe_track_interpolator_defines.svh"

module kti_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_found,
  input logic [1:0] out_status,
  input logic [6:0] out_key_count,
  input logic [5:0] out_prev_index,
  input logic [5:0] out_next_index
);
  import kti_pkg::*;

  // results are never back to back
  `KTI_ASSERT_NEXT(a_gap, out_valid, !out_valid)
  // a found bracket always reports ok status
  `KTI_ASSERT_IMPL(a_found_ok, out_valid && out_found, out_status == ST_OK)
  // an empty-table result reports no keys and no bracket
  `KTI_ASSERT_IMPL(a_empty, out_valid && (out_status == ST_EMPTY),
                   !out_found && (out_key_count == 7'd0) && (out_prev_index == 6'd0))
  // results that are not found carry zero indexes
  `KTI_ASSERT_IMPL(a_idx, out_valid && !out_found,
                   (out_prev_index == 6'd0) && (out_next_index == 6'd0))

endmodule

bind keyframe_track_interpolator kti_checker u_kti_checker (.*);

[bench/tb_keyframe_track_interpolator.sv]
// self-checking testbench for the keyframe track interpolator
module tb_keyframe_track_interpolator;
  import kti_pkg::*;

  localparam logic [1:0] CMD_UNUSED    = 2'd3;
  localparam logic [1:0] MODE_RESERVED = 2'd3;
  localparam int         TABLE_DEPTH   = DEF_MAX_KEYS;
  localparam int         FRAC          = DEF_FRAC_BITS;
  localparam int         DRAIN_CYCLES  = 300;
  localparam int         CYCLE_LIMIT   = 1000000;
  localparam int         RANDOM_ITEMS  = 400;

  // track predictor and result store
  class kti_scoreboard;
    logic signed [31:0] key_time[TABLE_DEPTH];
    logic signed [31:0] key_val[TABLE_DEPTH][4];
    int                 key_total;
    logic [1:0]         mode;
    logic [2:0]         comps;
    kti_result_t        pending[$];
    int                 errors;

    function new();
      key_total = 0;
      mode      = MODE_LINEAR;
      comps     = 3'd1;
      errors    = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] data);
      if (idx == REG_MODE) mode = data[1:0];
      else comps = data[2:0];
    endfunction

    function logic signed [31:0] sat32(longint v);
      if (v > longint'(32'sh7fffffff)) return 32'sh7fffffff;
      if (v < -longint'(64'sh80000000)) return 32'sh80000000;
      return v[31:0];
    endfunction

    // predict the result of one accepted command
    function void note_command(logic [1:0] cmd, logic signed [31:0] stime,
                               logic signed [31:0] vin[4]);
      kti_result_t r;
      int          pos, nx, pv;
      longint      num, span, frac, t2, s, a, b;
      r = '0;
      r.status = ST_OK;
      if (cmd == CMD_ADD) begin
        if (key_total >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < key_total && key_time[pos] <= stime) pos++;
          for (int i = key_total; i > pos; i--) begin
            key_time[i] = key_time[i-1];
            key_val[i]  = key_val[i-1];
          end
          key_time[pos] = stime;
          for (int c = 0; c < 4; c++) key_val[pos][c] = vin[c];
          key_total++;
        end
      end else if (cmd == CMD_CLEAR) begin
        key_total = 0;
      end else if (cmd == CMD_EVAL) begin
        if (key_total == 0) begin
          r.status = ST_EMPTY;
          if (comps == 3'd4) r.w = 32'sd1 <<< FRAC;
        end else begin
          r.found = 1'b1;
          if (stime <= key_time[0]) begin
            {r.x, r.y, r.z, r.w} = {key_val[0][0], key_val[0][1], key_val[0][2], key_val[0][3]};
          end else if (stime >= key_time[key_total-1]) begin
            pv = key_total - 1;
            r.prev_index = pv[5:0];
            r.next_index = pv[5:0];
            {r.x, r.y, r.z, r.w} = {key_val[pv][0], key_val[pv][1], key_val[pv][2],
                                    key_val[pv][3]};
          end else begin
            nx = 1;
            while (nx < key_total - 1 && key_time[nx] < stime) nx++;
            pv = nx - 1;
            r.prev_index = pv[5:0];
            r.next_index = nx[5:0];
            num  = longint'(stime) - longint'(key_time[pv]);
            span = longint'(key_time[nx]) - longint'(key_time[pv]);
            frac = (span > 0) ? (num <<< FRAC) / span : 0;
            if (mode == MODE_STEP) begin
              s = 0;
            end else if (mode == MODE_SMOOTH) begin
              t2 = (frac * frac) >>> FRAC;
              s  = (t2 * ((longint'(3) <<< FRAC) - 2 * frac)) >>> FRAC;
            end else begin
              s = frac;
            end
            a = key_val[pv][0]; b = key_val[nx][0]; r.x = sat32(a + (((b - a) * s) >>> FRAC));
            a = key_val[pv][1]; b = key_val[nx][1]; r.y = sat32(a + (((b - a) * s) >>> FRAC));
            a = key_val[pv][2]; b = key_val[nx][2]; r.z = sat32(a + (((b - a) * s) >>> FRAC));
            a = key_val[pv][3]; b = key_val[nx][3]; r.w = sat32(a + (((b - a) * s) >>> FRAC));
          end
        end
      end
      r.key_count = key_total[6:0];
      r.duration  = (key_total != 0) ? key_time[key_total-1] : 32'sd0;
      pending = {pending, r};
    endfunction

    // compare one result transfer with the oldest prediction
    function void check_result(kti_result_t got);
      kti_result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer: %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("result mismatch");
          $display("  expected x=%h y=%h z=%h w=%h prev=%0d next=%0d found=%b st=%0d n=%0d d=%h",
                   want.x, want.y, want.z, want.w, want.prev_index, want.next_index,
                   want.found, want.status, want.key_count, want.duration);
          $display("  actual   x=%h y=%h z=%h w=%h prev=%0d next=%0d found=%b st=%0d n=%0d d=%h",
                   got.x, got.y, got.z, got.w, got.prev_index, got.next_index,
                   got.found, got.status, got.key_count, got.duration);
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_command = CMD_EVAL;
  logic signed [31:0] in_sample_time = '0;
  logic signed [31:0] in_value_x = '0;
  logic signed [31:0] in_value_y = '0;
  logic signed [31:0] in_value_z = '0;
  logic signed [31:0] in_value_w = '0;
  logic               out_valid;
  logic signed [31:0] out_x, out_y, out_z, out_w;
  logic [5:0]         out_prev_index, out_next_index;
  logic               out_found;
  logic [1:0]         out_status;
  logic [6:0]         out_key_count;
  logic signed [31:0] out_duration;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  kti_scoreboard track_sb = new();
  int            idle_pct = 0;
  int            sent = 0;
  int            cycle_count = 0;

  keyframe_track_interpolator u_dut (.*);

  always #5 clk = ~clk;

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid)
      track_sb.check_result({out_x, out_y, out_z, out_w, out_prev_index, out_next_index,
                             out_found, out_status, out_key_count, out_duration});
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // one command transfer, sometimes with a random gap ahead of it
  task automatic send_cmd(logic [1:0] cmd, logic signed [31:0] stime,
                          logic signed [31:0] vx, logic signed [31:0] vy,
                          logic signed [31:0] vz, logic signed [31:0] vw);
    logic signed [31:0] vin[4];
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    vin = '{vx, vy, vz, vw};
    start          <= 1'b1;
    in_command     <= cmd;
    in_sample_time <= stime;
    in_value_x     <= vx;
    in_value_y     <= vy;
    in_value_z     <= vz;
    in_value_w     <= vw;
    do @(posedge clk); while (busy);
    track_sb.note_command(cmd, stime, vin);
    sent++;
  endtask

  // hold off until every prediction has been matched and the block is quiet
  task automatic drain();
    start <= 1'b0;
    while (track_sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write, only once every command in flight has finished
  task automatic cfg_write(logic idx, logic [31:0] data);
    start <= 1'b0;
    while (track_sb.pending.size() != 0) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    track_sb.write_reg(idx, data);
  endtask

  function automatic logic signed [31:0] rand_time();
    case ($urandom_range(7))
      0:       return $urandom;
      1:       return $signed($urandom_range(40)) <<< 16;
      default: return ($signed($urandom_range(64)) - 32) * 32'sd8192 + $signed($urandom_range(3));
    endcase
  endfunction

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(5))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return ($signed($urandom_range(200)) - 100) <<< 16;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_key(logic signed [31:0] stime);
    send_cmd(CMD_ADD, stime, rand_val(), rand_val(), rand_val(), rand_val());
  endtask

  task automatic eval_at(logic signed [31:0] stime);
    send_cmd(CMD_EVAL, stime, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    int phase;
    int n_add;
    int n_eval;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, default w, extremes, ties, clamps, unused code, modes, clear
    eval_at(32'sd0);
    cfg_write(REG_COUNT, 32'd4);
    eval_at(32'sh7fffffff);
    send_cmd(CMD_UNUSED, 32'sh80000000, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_cmd(CMD_ADD, 32'sh00010000, 32'sh7fffffff, 32'sh80000000, 32'sd0, 32'hffffffff);
    eval_at(32'sh00000000);
    eval_at(32'sh00020000);
    send_cmd(CMD_ADD, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh00010000, 32'sd5);
    send_cmd(CMD_ADD, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'shffff0000, 32'sd0);
    send_cmd(CMD_ADD, 32'sh00010000, 32'sd100, 32'sd200, 32'sd300, 32'sd400);
    eval_at(32'sh80000000);
    eval_at(32'sh7fffffff);
    eval_at(32'sh00008000);
    eval_at(32'sh00010000);
    eval_at(32'sh40000000);
    drain();
    cfg_write(REG_MODE, {30'd0, MODE_STEP});
    eval_at(32'shc0000000);
    cfg_write(REG_MODE, {30'd0, MODE_SMOOTH});
    eval_at(32'shc0000000);
    eval_at(32'sh00004000);
    cfg_write(REG_MODE, {30'd0, MODE_RESERVED});
    eval_at(32'sh00004000);
    send_cmd(CMD_CLEAR, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    eval_at(32'sd7);
    drain();

    // random phases: configure, clear, build a table, query it
    phase = 0;
    while (sent < RANDOM_ITEMS + 22) begin
      case (phase % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 62;
        default: idle_pct = 20;
      endcase
      case (phase % 5)
        0:       cfg_write(REG_MODE, {30'd0, MODE_STEP});
        1:       cfg_write(REG_MODE, {30'd0, MODE_LINEAR});
        4:       cfg_write(REG_MODE, {30'd0, MODE_RESERVED});
        default: cfg_write(REG_MODE, {30'd0, MODE_SMOOTH});
      endcase
      cfg_write(REG_COUNT, (phase % 4 == 0) ? 32'd4 : $urandom_range(7));
      send_cmd(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
      n_add  = (phase % 6 == 5) ? $urandom_range(64, 68) : $urandom_range(0, 8);
      n_eval = $urandom_range(3, 12);
      repeat (n_add) add_key(rand_time());
      repeat (n_eval) begin
        case ($urandom_range(15))
          0:       send_cmd(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
          1:       add_key(rand_time());
          default: eval_at(rand_time());
        endcase
      end
      drain();
      phase++;
    end

    cfg_write(REG_MODE, {30'd0, MODE_LINEAR});
    cfg_write(REG_COUNT, 32'd1);
    eval_at(32'sd0);
    drain();

    if (track_sb.errors == 0 && track_sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
